// File: sv/vad_pkg.sv
// Shared types and constants for the voice activity detector.
// No dependencies; imported by every module of the block.
package vad_pkg;

    localparam int FLEN_W   = 13;
    localparam int ELIM_W   = 43;
    localparam int CLIM_W   = 13;
    localparam int ENERGY_W = 43;
    localparam int CROSS_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 43;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [CROSS_W-1:0]  CROSS_MAX  = {CROSS_W{1'b1}};

    localparam logic [FLEN_W-1:0] FLEN_RESET = FLEN_W'(512);
    localparam logic [ELIM_W-1:0] ELIM_RESET = '0;
    localparam logic [CLIM_W-1:0] CLIM_RESET = CLIM_W'(4096);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_SUM_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CROSSING_LIMIT   = CFG_IDX_W'(2);

    typedef struct packed {
        logic [FLEN_W-1:0] frame_length;
        logic [ELIM_W-1:0] energy_sum_limit;
        logic [CLIM_W-1:0] crossing_limit;
    } cfg_t;

endpackage

// File: sv/vad_cfg_regs.sv
// Configuration register file of the voice activity detector.
// Depends on vad_pkg for register indexes, widths and reset values.
module vad_cfg_regs
    import vad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length     <= FLEN_RESET;
            cfg_reg.energy_sum_limit <= ELIM_RESET;
            cfg_reg.crossing_limit   <= CLIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_LENGTH:     cfg_reg.frame_length     <= cfg_data[FLEN_W-1:0];
                REG_ENERGY_SUM_LIMIT: cfg_reg.energy_sum_limit <= cfg_data[ELIM_W-1:0];
                REG_CROSSING_LIMIT:   cfg_reg.crossing_limit   <= cfg_data[CLIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: sv/vad_square_stage.sv
// Input register stage: takes a sample, registers its square and sign class.
// Depends on vad_pkg through the shared import; SAMPLE_BITS sets all widths here.
module vad_square_stage
    import vad_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_buffer_start,
    output logic                          sq_valid,
    input  logic                          sq_ready,
    output logic [2*SAMPLE_BITS-1:0]      sq_value,
    output logic                          sq_nonneg,
    output logic                          sq_start
);

    logic                     valid_reg;
    logic [2*SAMPLE_BITS-1:0] square_reg;
    logic                     nonneg_reg;
    logic                     start_reg;
    logic [SAMPLE_BITS-1:0]   raw;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] mag_wide;

    // magnitude of the most negative code is 2^(N-1), still fits unsigned N bits
    assign raw      = s_sample;
    assign mag      = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    assign mag_wide = {{SAMPLE_BITS{1'b0}}, mag};

    assign s_ready   = !valid_reg || sq_ready;
    assign sq_valid  = valid_reg;
    assign sq_value  = square_reg;
    assign sq_nonneg = nonneg_reg;
    assign sq_start  = start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            square_reg <= mag_wide * mag_wide;
            nonneg_reg <= ~raw[SAMPLE_BITS-1];
            start_reg  <= s_buffer_start;
        end
    end

endmodule

// File: sv/vad_frame_accum.sv
// Frame accumulator: sums squares, counts sign changes, decides voice per frame.
// Depends on vad_pkg for the configuration struct and saturation limits.
module vad_frame_accum
    import vad_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_FRAME   = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     sq_valid,
    output logic                     sq_ready,
    input  logic [2*SAMPLE_BITS-1:0] sq_value,
    input  logic                     sq_nonneg,
    input  logic                     sq_start,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_voice_active,
    output logic [ENERGY_W-1:0]      m_frame_energy,
    output logic [CROSS_W-1:0]       m_frame_crossings
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int LEN_W = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;

    logic [CNT_W-1:0]    count_reg, count_next, count_base;
    logic [ENERGY_W-1:0] energy_reg, energy_next, energy_base;
    logic [CROSS_W-1:0]  cross_reg, cross_next, cross_base;
    logic                prev_reg, prev_base;

    logic                m_valid_reg;
    logic                voice_reg;
    logic [ENERGY_W-1:0] out_energy_reg;
    logic [CROSS_W-1:0]  out_cross_reg;

    logic [LEN_W-1:0]    eff_len;
    logic [SUM_W-1:0]    energy_sum;
    logic                advance;
    logic                frame_done;
    logic                voice;

    assign sq_ready = !m_valid_reg || m_ready;
    assign advance  = sq_valid && sq_ready;

    always_comb begin
        if (cfg.frame_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (LEN_W'(cfg.frame_length) > LEN_W'(MAX_FRAME)) begin
            eff_len = LEN_W'(MAX_FRAME);
        end else begin
            eff_len = LEN_W'(cfg.frame_length);
        end
    end

    always_comb begin
        // buffer start drops the partial frame before this sample counts
        count_base  = sq_start ? '0 : count_reg;
        energy_base = sq_start ? '0 : energy_reg;
        cross_base  = sq_start ? '0 : cross_reg;
        prev_base   = sq_start ? 1'b0 : prev_reg;

        cross_next = cross_base;
        if (count_base != '0 && sq_nonneg != prev_base && cross_base != CROSS_MAX) begin
            cross_next = cross_base + CROSS_W'(1);
        end

        energy_sum = SUM_W'(energy_base) + SUM_W'(sq_value);
        if (energy_sum > SUM_W'(ENERGY_MAX)) begin
            energy_next = ENERGY_MAX;
        end else begin
            energy_next = energy_sum[ENERGY_W-1:0];
        end

        count_next = count_base + CNT_W'(1);
        frame_done = LEN_W'(count_next) >= eff_len;
        voice      = (energy_next > cfg.energy_sum_limit) &&
                     (CLIM_W'(cross_next) < cfg.crossing_limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            energy_reg <= '0;
            cross_reg  <= '0;
            prev_reg   <= 1'b0;
        end else if (advance) begin
            prev_reg <= sq_nonneg;
            if (frame_done) begin
                count_reg  <= '0;
                energy_reg <= '0;
                cross_reg  <= '0;
            end else begin
                count_reg  <= count_next;
                energy_reg <= energy_next;
                cross_reg  <= cross_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (sq_ready) begin
            m_valid_reg <= advance && frame_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_done) begin
            voice_reg      <= voice;
            out_energy_reg <= energy_next;
            out_cross_reg  <= cross_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_voice_active    = voice_reg;
    assign m_frame_energy    = out_energy_reg;
    assign m_frame_crossings = out_cross_reg;

endmodule

// File: sv/voice_activity_detector_unit.sv
// Voice activity detector over fixed-length frames of signed audio samples.
// Channels: s_ carries one sample per transfer with a buffer-start flag; m_ carries
// one result per completed frame (voice flag, energy sum, crossing count).
// cfg_ writes frame_length (index 0), energy_sum_limit (1), crossing_limit (2);
// cfg_ready is always high; the user makes writes only while the block is idle,
// which the block does not enforce. Pipeline: an input register holds the squared
// sample, then the frame accumulator updates its running sums and loads the
// result register, whose loading raises m_valid for the frame's last sample.
// Throughput: one sample per cycle while m_ready does not stall the result
// register, set by the saturating accumulate loop after the registered square.
// A stalled m_ready holds the result register; the input side keeps flowing
// until both the square register and the result register are full.
// Reset clears the configuration to its defaults (frame of 512 samples, energy
// limit 0, crossing limit 4096), empties both stages and drops any partial frame.
// Frames cut short by buffer start, or left unfinished, produce no result.
module voice_activity_detector_unit
    import vad_pkg::*;
#(
    parameter int MAX_FRAME   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_buffer_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_voice_active,
    output logic [ENERGY_W-1:0]           m_frame_energy,
    output logic [CROSS_W-1:0]            m_frame_crossings,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cfg_t                     cfg;
    logic                     sq_valid;
    logic                     sq_ready;
    logic [2*SAMPLE_BITS-1:0] sq_value;
    logic                     sq_nonneg;
    logic                     sq_start;

    vad_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vad_square_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_square (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_buffer_start (s_buffer_start),
        .sq_valid       (sq_valid),
        .sq_ready       (sq_ready),
        .sq_value       (sq_value),
        .sq_nonneg      (sq_nonneg),
        .sq_start       (sq_start)
    );

    vad_frame_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_FRAME   (MAX_FRAME)
    ) u_accum (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .sq_valid          (sq_valid),
        .sq_ready          (sq_ready),
        .sq_value          (sq_value),
        .sq_nonneg         (sq_nonneg),
        .sq_start          (sq_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_voice_active    (m_voice_active),
        .m_frame_energy    (m_frame_energy),
        .m_frame_crossings (m_frame_crossings)
    );

endmodule
